// File: design/assert_macros.svh
// Shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset
`define ETRM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included
`define ETRM_ASSERT_ALL(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/etrm_pkg.sv
`default_nettype none
package etrm_pkg;

    // Defaults for the top-level parameters
    localparam int ANGLE_BITS_DEF    = 16;
    localparam int ELEMENT_BITS_DEF  = 16;
    localparam int CORDIC_STAGES_DEF = 16;

    // Internal Q2.30 datapath width (holds angles up to 4 rad and sums)
    localparam int CW = 34;
    // Width used for element sums before conversion
    localparam int SW = 36;

    localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
    localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
    localparam logic signed [CW-1:0] TWO_PI_Q30  = 34'sd6746518852;
    localparam logic signed [CW-1:0] GAIN_Q30    = 34'sd652032874;

    // Truncated Q2.30 atan(2^-i)
    function automatic logic signed [CW-1:0] etrm_atan(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000008;
            5'd28: v = 32'h00000004;
            5'd29: v = 32'h00000002;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return $signed({2'b00, v});
    endfunction

endpackage
`default_nettype wire

// File: design/etrm_angles_if.sv
`default_nettype none
interface etrm_angles_if #(parameter int ANGLE_BITS = 16) ();
    logic                         valid;
    logic                         ready;
    logic signed [ANGLE_BITS-1:0] angle_x;
    logic signed [ANGLE_BITS-1:0] angle_y;
    logic signed [ANGLE_BITS-1:0] angle_z;

    modport source (output valid, angle_x, angle_y, angle_z, input ready);
    modport sink   (input valid, angle_x, angle_y, angle_z, output ready);
endinterface
`default_nettype wire

// File: design/etrm_matrix_if.sv
`default_nettype none
interface etrm_matrix_if #(parameter int ELEMENT_BITS = 16) ();
    logic                           valid;
    logic                           ready;
    logic signed [ELEMENT_BITS-1:0] rot_r0c0;
    logic signed [ELEMENT_BITS-1:0] rot_r0c1;
    logic signed [ELEMENT_BITS-1:0] rot_r0c2;
    logic signed [ELEMENT_BITS-1:0] rot_r1c0;
    logic signed [ELEMENT_BITS-1:0] rot_r1c1;
    logic signed [ELEMENT_BITS-1:0] rot_r1c2;
    logic signed [ELEMENT_BITS-1:0] rot_r2c0;
    logic signed [ELEMENT_BITS-1:0] rot_r2c1;
    logic signed [ELEMENT_BITS-1:0] rot_r2c2;

    modport source (output valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                    rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, input ready);
    modport sink   (input valid, rot_r0c0, rot_r0c1, rot_r0c2, rot_r1c0, rot_r1c1,
                    rot_r1c2, rot_r2c0, rot_r2c1, rot_r2c2, output ready);
endinterface
`default_nettype wire

// File: design/etrm_fold.sv
`default_nettype none
module etrm_fold #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                             clk,
    input  wire logic                             en,
    input  wire logic signed [ANGLE_BITS-1:0]     angle,
    output logic signed [etrm_pkg::CW-1:0]        z_out,
    output logic                                  neg_out
);
    import etrm_pkg::*;

    localparam int SHIFT = 33 - ANGLE_BITS;

    logic signed [CW-1:0] z_scaled;
    logic signed [CW-1:0] z_wrap;
    logic signed [CW-1:0] z_next;
    logic                 neg_next;
    logic signed [CW-1:0] z_reg;
    logic                 neg_reg;

    // Scale to Q2.30, wrap into [-pi, pi], fold into [-pi/2, pi/2]
    always_comb
    begin
        z_scaled = CW'(angle) <<< SHIFT;
        if (z_scaled > PI_Q30)
            z_wrap = z_scaled - TWO_PI_Q30;
        else if (z_scaled < -PI_Q30)
            z_wrap = z_scaled + TWO_PI_Q30;
        else
            z_wrap = z_scaled;
        neg_next = 1'b0;
        z_next   = z_wrap;
        if (z_wrap > HALF_PI_Q30)
        begin
            z_next   = PI_Q30 - z_wrap;
            neg_next = 1'b1;
        end
        else if (z_wrap < -HALF_PI_Q30)
        begin
            z_next   = -PI_Q30 - z_wrap;
            neg_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            z_reg   <= z_next;
            neg_reg <= neg_next;
        end
    end

    assign z_out   = z_reg;
    assign neg_out = neg_reg;
endmodule
`default_nettype wire

// File: design/etrm_cordic_cell.sv
`default_nettype none
module etrm_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                         clk,
    input  wire logic                         en,
    input  wire logic signed [etrm_pkg::CW-1:0] x_in,
    input  wire logic signed [etrm_pkg::CW-1:0] y_in,
    input  wire logic signed [etrm_pkg::CW-1:0] z_in,
    input  wire logic                         neg_in,
    output logic signed [etrm_pkg::CW-1:0]    x_out,
    output logic signed [etrm_pkg::CW-1:0]    y_out,
    output logic signed [etrm_pkg::CW-1:0]    z_out,
    output logic                              neg_out
);
    import etrm_pkg::*;

    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] at;
    logic signed [CW-1:0] x_next;
    logic signed [CW-1:0] y_next;
    logic signed [CW-1:0] z_next;
    logic signed [CW-1:0] x_reg;
    logic signed [CW-1:0] y_reg;
    logic signed [CW-1:0] z_reg;
    logic                 neg_reg;

    // One micro-rotation, direction from the sign of residual angle
    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        at = etrm_atan(5'(STAGE));
        if (!z_in[CW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - at;
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + at;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            z_reg   <= z_next;
            neg_reg <= neg_in;
        end
    end

    assign x_out   = x_reg;
    assign y_out   = y_reg;
    assign z_out   = z_reg;
    assign neg_out = neg_reg;
endmodule
`default_nettype wire

// File: design/etrm_matrix.sv
`default_nettype none
module etrm_matrix #(
    parameter int ELEMENT_BITS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           en,
    input  wire logic signed [etrm_pkg::CW-1:0] sb,
    input  wire logic signed [etrm_pkg::CW-1:0] cb,
    input  wire logic signed [etrm_pkg::CW-1:0] sa,
    input  wire logic signed [etrm_pkg::CW-1:0] ca,
    input  wire logic signed [etrm_pkg::CW-1:0] sh,
    input  wire logic signed [etrm_pkg::CW-1:0] ch,
    output logic signed [ELEMENT_BITS-1:0]      elem [9]
);
    import etrm_pkg::*;

    localparam int S  = 32 - ELEMENT_BITS;
    localparam int SR = (S > 0) ? S - 1 : 0;
    localparam logic signed [SW-1:0] HALF = (S > 0) ? (SW'(1) <<< SR) : '0;
    localparam logic signed [SW-1:0] LIM  = SW'(1) <<< (ELEMENT_BITS - 2);

    // Q2.30 product rounded back to Q2.30
    function automatic logic signed [CW-1:0] mul30(input logic signed [CW-1:0] a,
                                                   input logic signed [CW-1:0] b);
        logic signed [2*CW-1:0] p;
        p = a * b + (2*CW)'(64'sd536870912);
        return p[CW+29:30];
    endfunction

    // Round to output format and saturate
    function automatic logic signed [ELEMENT_BITS-1:0] to_elem(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + HALF) >>> S;
        if (r > LIM)
            r = LIM;
        if (r < -LIM)
            r = -LIM;
        return r[ELEMENT_BITS-1:0];
    endfunction

    // Stage 1: pair products, pass sa, sb and cb
    logic signed [CW-1:0] chca_reg, shsb_reg, chsa_reg, shcb_reg, cacb_reg;
    logic signed [CW-1:0] casb_reg, shca_reg, shsa_reg, chsb_reg, chcb_reg;
    logic signed [CW-1:0] sa1_reg, sb1_reg, cb1_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            chca_reg <= mul30(ch, ca);
            shsb_reg <= mul30(sh, sb);
            chsa_reg <= mul30(ch, sa);
            shcb_reg <= mul30(sh, cb);
            cacb_reg <= mul30(ca, cb);
            casb_reg <= mul30(ca, sb);
            shca_reg <= mul30(sh, ca);
            shsa_reg <= mul30(sh, sa);
            chsb_reg <= mul30(ch, sb);
            chcb_reg <= mul30(ch, cb);
            sa1_reg  <= sa;
            sb1_reg  <= sb;
            cb1_reg  <= cb;
        end
    end

    // Stage 2: triple products, pass the rest
    logic signed [CW-1:0] t1_reg, t2_reg, t7_reg, t8_reg;
    logic signed [CW-1:0] p0_reg, p1_reg, p2_reg, p3_reg, p4_reg;
    logic signed [CW-1:0] p5_reg, p6_reg, p7_reg, p8_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg <= mul30(chsa_reg, cb1_reg);
            t2_reg <= mul30(chsa_reg, sb1_reg);
            t7_reg <= mul30(shsa_reg, cb1_reg);
            t8_reg <= mul30(shsa_reg, sb1_reg);
            p0_reg <= chca_reg;
            p1_reg <= shsb_reg;
            p2_reg <= shcb_reg;
            p3_reg <= sa1_reg;
            p4_reg <= cacb_reg;
            p5_reg <= casb_reg;
            p6_reg <= shca_reg;
            p7_reg <= chsb_reg;
            p8_reg <= chcb_reg;
        end
    end

    // Stage 3: sums, conversion and output register
    logic signed [ELEMENT_BITS-1:0] elem_next [9];
    logic signed [ELEMENT_BITS-1:0] elem_reg  [9];

    always_comb
    begin
        elem_next[0] = to_elem(SW'(p0_reg));
        elem_next[1] = to_elem(SW'(p1_reg) - SW'(t1_reg));
        elem_next[2] = to_elem(SW'(t2_reg) + SW'(p2_reg));
        elem_next[3] = to_elem(SW'(p3_reg));
        elem_next[4] = to_elem(SW'(p4_reg));
        elem_next[5] = to_elem(-SW'(p5_reg));
        elem_next[6] = to_elem(-SW'(p6_reg));
        elem_next[7] = to_elem(SW'(t7_reg) + SW'(p7_reg));
        elem_next[8] = to_elem(SW'(p8_reg) - SW'(t8_reg));
    end

    always_ff @(posedge clk)
    begin
        if (en)
            elem_reg <= elem_next;
    end

    assign elem = elem_reg;
endmodule
`default_nettype wire

// File: design/euler_to_rotation_matrix.sv
// Channel   Modport  Payload                         Meaning
// angles    sink     angle_x, angle_y, angle_z       Euler angles, Q3.13 rad
// rot       source   rot_r0c0 .. rot_r2c2            rotation matrix, Q1.14
//
// One request enters per cycle unless the output stalls. The chain is a
// fold stage, one CORDIC cell per stage and three product/sum stages.
// The depth is set by the CORDIC cell chain, one cell per iteration.
// Reset clears only the per-stage valid bits; the datapath is not reset.
// A stalled result freezes the whole chain, bubbles included; input ready
// stays high while the output slot is empty or being drained.
`default_nettype none
module euler_to_rotation_matrix #(
    parameter int ANGLE_BITS    = etrm_pkg::ANGLE_BITS_DEF,
    parameter int ELEMENT_BITS  = etrm_pkg::ELEMENT_BITS_DEF,
    parameter int CORDIC_STAGES = etrm_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    etrm_angles_if.sink   angles,
    etrm_matrix_if.source rot
);
    import etrm_pkg::*;
    `include "assert_macros.svh"

    localparam int L = CORDIC_STAGES + 4;

    logic [L-1:0] vld_reg;
    logic         advance;

    // Chain moves whenever the output slot is free or being drained
    assign advance      = !vld_reg[L-1] || rot.ready;
    assign angles.ready = advance;
    assign rot.valid    = vld_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (advance)
            vld_reg <= {vld_reg[L-2:0], angles.valid};
    end

    // Three CORDIC lanes: bank, attitude, heading
    logic signed [ANGLE_BITS-1:0] lane_angle [3];
    logic signed [CW-1:0] cx [3][CORDIC_STAGES+1];
    logic signed [CW-1:0] cy [3][CORDIC_STAGES+1];
    logic signed [CW-1:0] cz [3][CORDIC_STAGES+1];
    logic                 cn [3][CORDIC_STAGES+1];
    logic signed [CW-1:0] sin_l [3];
    logic signed [CW-1:0] cos_l [3];

    assign lane_angle[0] = angles.angle_x;
    assign lane_angle[1] = angles.angle_y;
    assign lane_angle[2] = angles.angle_z;

    for (genvar l = 0; l < 3; l++)
    begin : g_lane
        etrm_fold #(.ANGLE_BITS(ANGLE_BITS)) u_fold (
            .clk     (clk),
            .en      (advance),
            .angle   (lane_angle[l]),
            .z_out   (cz[l][0]),
            .neg_out (cn[l][0])
        );
        assign cx[l][0] = GAIN_Q30;
        assign cy[l][0] = '0;

        for (genvar s = 0; s < CORDIC_STAGES; s++)
        begin : g_stage
            etrm_cordic_cell #(.STAGE(s)) u_cell (
                .clk     (clk),
                .en      (advance),
                .x_in    (cx[l][s]),
                .y_in    (cy[l][s]),
                .z_in    (cz[l][s]),
                .neg_in  (cn[l][s]),
                .x_out   (cx[l][s+1]),
                .y_out   (cy[l][s+1]),
                .z_out   (cz[l][s+1]),
                .neg_out (cn[l][s+1])
            );
        end

        // Undo the fold on the cosine
        assign sin_l[l] = cy[l][CORDIC_STAGES];
        assign cos_l[l] = cn[l][CORDIC_STAGES] ? -cx[l][CORDIC_STAGES]
                                               : cx[l][CORDIC_STAGES];
    end

    logic signed [ELEMENT_BITS-1:0] elem [9];

    etrm_matrix #(.ELEMENT_BITS(ELEMENT_BITS)) u_matrix (
        .clk  (clk),
        .en   (advance),
        .sb   (sin_l[0]),
        .cb   (cos_l[0]),
        .sa   (sin_l[1]),
        .ca   (cos_l[1]),
        .sh   (sin_l[2]),
        .ch   (cos_l[2]),
        .elem (elem)
    );

    assign rot.rot_r0c0 = elem[0];
    assign rot.rot_r0c1 = elem[1];
    assign rot.rot_r0c2 = elem[2];
    assign rot.rot_r1c0 = elem[3];
    assign rot.rot_r1c1 = elem[4];
    assign rot.rot_r1c2 = elem[5];
    assign rot.rot_r2c0 = elem[6];
    assign rot.rot_r2c1 = elem[7];
    assign rot.rot_r2c2 = elem[8];

    // Checks
    `ETRM_ASSERT(a_stall_holds, !advance |=> $stable(vld_reg), "valid chain moved on stall")
    `ETRM_ASSERT(a_ready_free, !angles.ready |-> rot.valid, "input blocked with empty output")
    `ETRM_ASSERT(a_chain_shift, advance |=> (vld_reg[0] == $past(angles.valid)), "request lost at chain head")
    `ETRM_ASSERT_ALL(a_reset_clear, !rst_n |=> (vld_reg == '0), "valid bits set in reset")
endmodule
`default_nettype wire
